/* hw/rtl/qwo_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and constants for the quadrature wheel odometry block.
// No dependencies; every other file in hw/rtl imports this package.

package qwo_pkg;

   // Datapath widths
   localparam int CNT_W       = 32;   // wheel counter width (COUNT_BITS)
   localparam int SPEED_W     = 24;   // velocity result width (SPEED_BITS)
   localparam int STAMP_W     = 32;
   localparam int INTERVAL_W  = 16;
   localparam int UMPC_W      = 20;
   localparam int TRACK_W     = 16;
   localparam int SUM_W       = SPEED_W + 1;

   // Configuration port
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 20;

   // Register reset values
   localparam int INTERVAL_RST = 20;
   localparam int UMPC_RST     = 1000;
   localparam int TRACK_RST    = 500;

   // Serial divider: dividend is |delta| * um_per_count, divisor is 16 bit
   localparam int DIVN_W      = CNT_W + UMPC_W;
   localparam int DIVD_W      = 16;
   localparam int DIV_CNT_W   = $clog2(DIVN_W);

   // Turn rate scaling: rad -> mrad
   localparam int MRAD_PER_RAD = 1000;
   localparam int TURN_PROD_W  = SUM_W + 10;

   // Largest magnitude of a negative speed
   localparam longint SPD_MAG = 64'd1 << (SPEED_W - 1);

   // Snapshot queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INTERVAL    = 3'd0,
      CSR_LEFT_REV    = 3'd1,
      CSR_RIGHT_REV   = 3'd2,
      CSR_LEFT_UMPC   = 3'd3,
      CSR_RIGHT_UMPC  = 3'd4,
      CSR_TRACK       = 3'd5
   } csr_idx_type;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_CLEAR  = 1'b1
   } cmd_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_MUL_L,
      B_DIV_L,
      B_WAIT_L,
      B_MUL_R,
      B_DIV_R,
      B_WAIT_R,
      B_MUL_T,
      B_DIV_T,
      B_WAIT_T,
      B_EMIT
   } back_state_type;

   typedef struct packed {
      logic cmd;
      logic left_a;
      logic left_b;
      logic right_a;
      logic right_b;
      logic ms_tick;
   } req_type;

   typedef struct packed {
      logic signed [CNT_W-1:0]   left_total;
      logic signed [CNT_W-1:0]   right_total;
      logic        [STAMP_W-1:0] stamp_ms;
      logic signed [SPEED_W-1:0] left_speed;
      logic signed [SPEED_W-1:0] right_speed;
      logic signed [SPEED_W-1:0] body_speed;
      logic signed [SPEED_W-1:0] turn_rate;
   } rsp_type;

   typedef struct packed {
      logic [INTERVAL_W-1:0] period_ms;
      logic                  left_reverse;
      logic                  right_reverse;
      logic [UMPC_W-1:0]     left_um_per_count;
      logic [UMPC_W-1:0]     right_um_per_count;
      logic [TRACK_W-1:0]    track_width_mm;
   } cfg_type;

   // One snapshot handed from the front to the back
   typedef struct packed {
      logic signed [CNT_W-1:0]      left_total;
      logic signed [CNT_W-1:0]      right_total;
      logic        [STAMP_W-1:0]    stamp_ms;
      logic signed [CNT_W-1:0]      left_delta;
      logic signed [CNT_W-1:0]      right_delta;
      logic        [INTERVAL_W-1:0] elapsed_ms;
      logic                         have_prev;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } job_push_type;

   typedef struct packed {
      logic              start;
      logic [DIVN_W-1:0] dividend;
      logic [DIVD_W-1:0] divisor;
   } div_req_type;

   // Apply sign to a quotient magnitude and clamp to the signed speed range
   function automatic logic signed [SPEED_W-1:0] sat_speed(input logic [DIVN_W-1:0] q,
                                                         input logic neg);
      logic [DIVN_W-1:0]  lim;
      logic [SPEED_W-1:0] m;
      lim = DIVN_W'(SPD_MAG);
      m   = q[SPEED_W-1:0];
      if (neg) begin
         if (q >= lim) return {1'b1, {(SPEED_W-1){1'b0}}};
         return -$signed(m);
      end
      if (q >= lim) return {1'b0, {(SPEED_W-1){1'b1}}};
      return $signed(m);
   endfunction

endpackage

/* hw/rtl/qwo_div.sv */
`timescale 1ns / 1ps
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on qwo_pkg for widths and the request struct.

module qwo_div (
   input  logic                        clock,
   input  logic                        reset,
   input  qwo_pkg::div_req_type        req,
   output logic                        done,
   output logic [qwo_pkg::DIVN_W-1:0]  quotient
);
   import qwo_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIVD_W-1:0]    rem_ff, rem_in;
   logic [DIVN_W-1:0]    quo_ff, quo_in;
   logic [DIVD_W-1:0]    dvs_ff, dvs_in;

   logic [DIVD_W:0]      shifted;
   logic [DIVD_W:0]      trial;
   logic                 ge;

   assign shifted = {rem_ff, quo_ff[DIVN_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign ge      = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? trial[DIVD_W-1:0] : shifted[DIVD_W-1:0];
         quo_in = {quo_ff[DIVN_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIVN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider finished without running");
`endif

endmodule

/* hw/rtl/qwo_front.sv */
`timescale 1ns / 1ps
// Front end: decodes encoder edges, keeps counts and the ms clock, and
// queues a snapshot request when the interval elapses. Depends on qwo_pkg.

module qwo_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  qwo_pkg::req_type      req,
   input  qwo_pkg::cfg_type      cfg,
   output qwo_pkg::job_push_type snap
);
   import qwo_pkg::*;

   logic                  last_la_ff, last_la_in;
   logic                  last_ra_ff, last_ra_in;
   logic [CNT_W-1:0]      lcnt_ff, lcnt_in;
   logic [CNT_W-1:0]      rcnt_ff, rcnt_in;
   logic [CNT_W-1:0]      prevl_ff, prevl_in;
   logic [CNT_W-1:0]      prevr_ff, prevr_in;
   logic                  havep_ff, havep_in;
   logic [INTERVAL_W-1:0] since_ff, since_in;
   logic [STAMP_W-1:0]    clock_ms_ff, clock_ms_in;

   logic                  l_up, r_up;
   logic [CNT_W-1:0]      lcnt_new, rcnt_new;
   logic [INTERVAL_W-1:0] since_inc, limit;

   assign l_up = (req.left_a ^ req.left_b) ^ cfg.left_reverse;
   assign r_up = (req.right_a ^ req.right_b) ^ cfg.right_reverse;

   // Step only on a change of A
   assign lcnt_new = (req.left_a == last_la_ff) ? lcnt_ff
                   : (l_up ? lcnt_ff + 1'b1 : lcnt_ff - 1'b1);
   assign rcnt_new = (req.right_a == last_ra_ff) ? rcnt_ff
                   : (r_up ? rcnt_ff + 1'b1 : rcnt_ff - 1'b1);

   assign since_inc = (since_ff == {INTERVAL_W{1'b1}}) ? since_ff : since_ff + 1'b1;
   assign limit     = (cfg.period_ms == '0) ? INTERVAL_W'(1) : cfg.period_ms;

   always_comb begin
      last_la_in  = last_la_ff;
      last_ra_in  = last_ra_ff;
      lcnt_in     = lcnt_ff;
      rcnt_in     = rcnt_ff;
      prevl_in    = prevl_ff;
      prevr_in    = prevr_ff;
      havep_in    = havep_ff;
      since_in    = since_ff;
      clock_ms_in = clock_ms_ff;

      snap.push             = 1'b0;
      snap.job.left_total   = lcnt_new;
      snap.job.right_total  = rcnt_new;
      snap.job.stamp_ms     = clock_ms_ff + 1'b1;
      snap.job.left_delta   = lcnt_new - prevl_ff;
      snap.job.right_delta  = rcnt_new - prevr_ff;
      snap.job.elapsed_ms   = since_inc;
      snap.job.have_prev    = havep_ff;

      if (accept) begin
         if (req.cmd == CMD_CLEAR) begin
            lcnt_in  = '0;
            rcnt_in  = '0;
            prevl_in = '0;
            prevr_in = '0;
            havep_in = 1'b0;
            since_in = '0;
         end else begin
            lcnt_in    = lcnt_new;
            rcnt_in    = rcnt_new;
            last_la_in = req.left_a;
            last_ra_in = req.right_a;
            if (req.ms_tick) begin
               clock_ms_in = clock_ms_ff + 1'b1;
               since_in    = since_inc;
               if (since_inc >= limit) begin
                  snap.push = 1'b1;
                  prevl_in  = lcnt_new;
                  prevr_in  = rcnt_new;
                  havep_in  = 1'b1;
                  since_in  = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_la_ff  <= 1'b0;
         last_ra_ff  <= 1'b0;
         lcnt_ff     <= '0;
         rcnt_ff     <= '0;
         prevl_ff    <= '0;
         prevr_ff    <= '0;
         havep_ff    <= 1'b0;
         since_ff    <= '0;
         clock_ms_ff <= '0;
      end else begin
         last_la_ff  <= last_la_in;
         last_ra_ff  <= last_ra_in;
         lcnt_ff     <= lcnt_in;
         rcnt_ff     <= rcnt_in;
         prevl_ff    <= prevl_in;
         prevr_ff    <= prevr_in;
         havep_ff    <= havep_in;
         since_ff    <= since_in;
         clock_ms_ff <= clock_ms_in;
      end
   end

endmodule

/* hw/rtl/qwo_queue.sv */
`timescale 1ns / 1ps
// Short snapshot queue that decouples the front end from the velocity back end.
// Depends on qwo_pkg for the job types and queue depth.

module qwo_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  qwo_pkg::job_push_type wr,
   input  logic                  pop,
   output logic                  full,
   output logic                  empty,
   output qwo_pkg::job_type      head
);
   import qwo_pkg::*;

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr.push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr.push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !wr.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (wr.push) begin
         slot_ff[wr_ptr_ff] <= wr.job;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("snapshot queue overflow");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      (wr.push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("snapshot queue lost a push");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("snapshot queue popped while empty");
`endif

endmodule

/* hw/rtl/qwo_back.sv */
`timescale 1ns / 1ps
// Back end: turns queued snapshots into wheel, body and turn velocities with a
// shared multiplier and serial divider, and holds the result register. Uses qwo_pkg, qwo_div.

module qwo_back (
   input  logic             clock,
   input  logic             reset,
   input  qwo_pkg::cfg_type cfg,
   input  logic             q_empty,
   input  qwo_pkg::job_type q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output qwo_pkg::rsp_type rsp_data
);
   import qwo_pkg::*;

   back_state_type            state_ff, state_in;
   job_type                   job_ff, job_in;
   logic [DIVN_W-1:0]         prod_ff, prod_in;
   logic                      neg_ff, neg_in;
   logic signed [SPEED_W-1:0] vl_ff, vl_in;
   logic signed [SPEED_W-1:0] vr_ff, vr_in;
   logic signed [SPEED_W-1:0] vb_ff, vb_in;
   logic signed [SPEED_W-1:0] wt_ff, wt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]          mag_l, mag_r, mul_a;
   logic [UMPC_W-1:0]         mul_b;
   logic [DIVN_W-1:0]         mul_p;
   logic [SUM_W-1:0]          diff, sum, sum_adj, tmag;
   logic [TURN_PROD_W-1:0]    tprod;
   div_req_type               div_req;
   logic                      div_done;
   logic [DIVN_W-1:0]         div_q;

   qwo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_q)
   );

   assign mag_l = job_ff.left_delta[CNT_W-1]  ? CNT_W'(-job_ff.left_delta)  : job_ff.left_delta;
   assign mag_r = job_ff.right_delta[CNT_W-1] ? CNT_W'(-job_ff.right_delta) : job_ff.right_delta;

   // One multiplier shared by both wheels
   assign mul_a = (state_ff == B_MUL_R) ? mag_r : mag_l;
   assign mul_b = (state_ff == B_MUL_R) ? cfg.right_um_per_count : cfg.left_um_per_count;
   assign mul_p = {{UMPC_W{1'b0}}, mul_a} * {{CNT_W{1'b0}}, mul_b};

   assign diff    = {vr_ff[SPEED_W-1], vr_ff} - {vl_ff[SPEED_W-1], vl_ff};
   assign sum     = {vr_ff[SPEED_W-1], vr_ff} + {vl_ff[SPEED_W-1], vl_ff};
   assign sum_adj = sum + SUM_W'(sum[SUM_W-1]);
   assign tmag    = diff[SUM_W-1] ? -diff : diff;
   assign tprod   = TURN_PROD_W'(tmag) * TURN_PROD_W'(MRAD_PER_RAD);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      vl_in        = vl_ff;
      vr_in        = vr_ff;
      vb_in        = vb_ff;
      wt_in        = wt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_pop        = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = prod_ff;
      div_req.divisor  = (state_ff == B_DIV_T) ? cfg.track_width_mm : job_ff.elapsed_ms;

      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               job_in   = q_head;
               state_in = B_MUL_L;
            end
         end
         B_MUL_L: begin
            if (!job_ff.have_prev) begin
               // first snapshot after reset or clear reports no motion
               vl_in    = '0;
               vr_in    = '0;
               vb_in    = '0;
               wt_in    = '0;
               state_in = B_EMIT;
            end else begin
               prod_in  = mul_p;
               neg_in   = job_ff.left_delta[CNT_W-1];
               state_in = B_DIV_L;
            end
         end
         B_DIV_L: begin
            div_req.start = 1'b1;
            state_in      = B_WAIT_L;
         end
         B_WAIT_L: begin
            if (div_done) begin
               vl_in    = sat_speed(div_q, neg_ff);
               state_in = B_MUL_R;
            end
         end
         B_MUL_R: begin
            prod_in  = mul_p;
            neg_in   = job_ff.right_delta[CNT_W-1];
            state_in = B_DIV_R;
         end
         B_DIV_R: begin
            div_req.start = 1'b1;
            state_in      = B_WAIT_R;
         end
         B_WAIT_R: begin
            if (div_done) begin
               vr_in    = sat_speed(div_q, neg_ff);
               state_in = B_MUL_T;
            end
         end
         B_MUL_T: begin
            // mean speed truncates toward zero
            vb_in   = sum_adj[SUM_W-1:1];
            neg_in  = diff[SUM_W-1];
            prod_in = DIVN_W'(tprod);
            if (cfg.track_width_mm == '0) begin
               wt_in    = '0;
               state_in = B_EMIT;
            end else begin
               state_in = B_DIV_T;
            end
         end
         B_DIV_T: begin
            div_req.start = 1'b1;
            state_in      = B_WAIT_T;
         end
         B_WAIT_T: begin
            if (div_done) begin
               wt_in    = sat_speed(div_q, neg_ff);
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.left_total  = job_ff.left_total;
               rsp_data_in.right_total = job_ff.right_total;
               rsp_data_in.stamp_ms    = job_ff.stamp_ms;
               rsp_data_in.left_speed  = vl_ff;
               rsp_data_in.right_speed = vr_ff;
               rsp_data_in.body_speed  = vb_ff;
               rsp_data_in.turn_rate   = wt_ff;
               state_in                = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff      <= job_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      vl_ff       <= vl_in;
      vr_ff       <= vr_in;
      vb_ff       <= vb_in;
      wt_ff       <= wt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hw/rtl/quadrature_wheel_odometry.sv */
`timescale 1ns / 1ps
// Top level of the quadrature wheel odometry block: configuration registers,
// front end, snapshot queue and velocity back end. Uses qwo_pkg and all qwo_* modules.

// Differential-drive odometry from two quadrature encoders. Each request
// carries one sample of both wheels' A/B pins, a millisecond tick flag and a
// command bit (sample or clear). A change of A steps that wheel's 32-bit count
// up when B differs from A and down otherwise (inverted by the reverse bits);
// counts wrap. Every period_ms ticks a snapshot response carries both
// counts, the ms stamp and the left, right, body (mm/s) and turn (mrad/s)
// rates, truncated toward zero and saturated to 24 bits; the first snapshot
// after reset or clear reports zero rates. Rate: requests are taken one per
// cycle while req_stall is low; the front end registers counts and timers
// as each request is taken. Each snapshot then passes through the back end:
// it is popped, then for each of left, right and turn the product is
// formed, the shared one-bit-per-cycle divider is launched and runs through
// its 52 quotient bits and flags done, and the response register is loaded
// once it is free. A zero track width skips the turn divide; a first
// snapshot after reset or clear skips all math. A two-entry queue holds
// pending snapshots, and req_stall rises only while that queue is full.
// Configuration writes are always ready and must be issued only while the
// block is idle.

module quadrature_wheel_odometry (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  qwo_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output qwo_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [qwo_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [qwo_pkg::CSR_DATA_W-1:0]    csr_data
);
   import qwo_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         req_accept;
   job_push_type snap;
   logic         q_full, q_empty, q_pop;
   job_type      q_head;

   // Register writes land at once; no side effects to wait on
   assign csr_ready = 1'b1;

   // Hold the request only when no room is left for a snapshot
   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_INTERVAL:   cfg_in.period_ms          = csr_data[INTERVAL_W-1:0];
            CSR_LEFT_REV:   cfg_in.left_reverse       = csr_data[0];
            CSR_RIGHT_REV:  cfg_in.right_reverse      = csr_data[0];
            CSR_LEFT_UMPC:  cfg_in.left_um_per_count  = csr_data[UMPC_W-1:0];
            CSR_RIGHT_UMPC: cfg_in.right_um_per_count = csr_data[UMPC_W-1:0];
            CSR_TRACK:      cfg_in.track_width_mm     = csr_data[TRACK_W-1:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_ms          <= INTERVAL_W'(INTERVAL_RST);
         cfg_ff.left_reverse       <= 1'b0;
         cfg_ff.right_reverse      <= 1'b0;
         cfg_ff.left_um_per_count  <= UMPC_W'(UMPC_RST);
         cfg_ff.right_um_per_count <= UMPC_W'(UMPC_RST);
         cfg_ff.track_width_mm     <= TRACK_W'(TRACK_RST);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: edge decode, counters, ms clock, snapshot trigger
   qwo_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .req    (req_data),
      .cfg    (cfg_ff),
      .snap   (snap)
   );

   // Queue: pending snapshots between front and back
   qwo_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (snap),
      .pop   (q_pop),
      .full  (q_full),
      .empty (q_empty),
      .head  (q_head)
   );

   // Back: velocity math and the response register
   qwo_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
